FILE: src/isv_pkg.sv
// shared types and constants of the image signature validator
package isv_pkg;

    typedef logic [7:0] byte_t;

    localparam int HEAD_DEPTH = 24;
    localparam int TAIL_DEPTH = 4;
    localparam int CFG_W      = 32;

    localparam logic [CFG_W-1:0] MAX_PIXELS_RESET = 32'd4194304;

    // png signature followed by the ihdr length and tag
    localparam int PNG_HEAD_LEN = 16;
    localparam byte_t PNG_HEAD [PNG_HEAD_LEN] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52
    };
    localparam byte_t JPEG_SOI [3] = '{8'hFF, 8'hD8, 8'hFF};
    localparam byte_t JPEG_EOI [2] = '{8'hFF, 8'hD9};
    localparam byte_t PNG_IEND [TAIL_DEPTH] = '{8'hAE, 8'h42, 8'h60, 8'h82};

    // width and height start in the head store
    localparam int WIDTH_POS  = 16;
    localparam int HEIGHT_POS = 20;

    // result bits in m_tdata
    localparam int OUT_IMAGE_VALID = 0;
    localparam int OUT_JPEG_PATH   = 1;

    // what one head cell shows once the current byte is stored
    typedef struct packed {
        logic  have;
        byte_t val;
    } isv_cell_view_t;

    // file summary taken on the last byte
    typedef struct packed {
        logic        jpeg;
        logic        jpeg_ok;
        logic        png_ok;
        logic [31:0] width;
        logic [31:0] height;
    } isv_snap_t;

endpackage

FILE: src/isv_head_cell.sv
// one cell of the head store chain: holds one byte and passes its fill mark on
module isv_head_cell
    import isv_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           clr,
    input  logic           tok_in,
    input  byte_t          byte_in,
    output logic           filled,
    output isv_cell_view_t view
);

    logic  filled_reg;
    logic  filled_next;
    byte_t data_reg;
    logic  tok;

    // the write position is the first cell not yet filled
    assign tok = tok_in & ~filled_reg;

    always_comb
    begin
        filled_next = filled_reg;
        if (en)
        begin
            filled_next = clr ? 1'b0 : (filled_reg | tok);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tok)
        begin
            data_reg <= byte_in;
        end
    end

    assign filled    = filled_reg;
    assign view.have = filled_reg | tok;
    assign view.val  = tok ? byte_in : data_reg;

endmodule

FILE: src/isv_verdict.sv
// verdict pipeline: pixel product, limit compare and output register
module isv_verdict
    import isv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  isv_snap_t        in_snap,
    input  logic [CFG_W-1:0] max_pixels,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_data
);

    logic        s1_valid_reg;
    isv_snap_t   s1_snap_reg;
    logic        s2_valid_reg;
    logic        s2_jpeg_reg;
    logic        s2_jok_reg;
    logic        s2_pok_reg;
    logic [63:0] s2_prod_reg;
    logic        out_valid_reg;
    logic [1:0]  out_data_reg;
    logic [1:0]  out_data_next;
    logic        en1;
    logic        en2;
    logic        en_out;
    logic        prod_ok;

    assign en_out   = ~out_valid_reg | out_ready;
    assign en2      = ~s2_valid_reg | en_out;
    assign en1      = ~s1_valid_reg | en2;
    assign in_ready = en1;

    assign prod_ok = (s2_prod_reg[63:32] == 32'd0) && (s2_prod_reg[31:0] <= max_pixels);

    always_comb
    begin
        out_data_next                  = 2'b00;
        out_data_next[OUT_JPEG_PATH]   = s2_jpeg_reg;
        out_data_next[OUT_IMAGE_VALID] = s2_jpeg_reg ? s2_jok_reg : (s2_pok_reg & prod_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_snap_reg <= in_snap;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_jpeg_reg <= s1_snap_reg.jpeg;
            s2_jok_reg  <= s1_snap_reg.jpeg_ok;
            s2_pok_reg  <= s1_snap_reg.png_ok && (s1_snap_reg.width != 32'd0)
                           && (s1_snap_reg.height != 32'd0);
            s2_prod_reg <= 64'(s1_snap_reg.width) * 64'(s1_snap_reg.height);
        end
        if (en_out && s2_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a stall at the input means every stage holds a verdict
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted request lost at first stage");

    a_product_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (en2 && s1_valid_reg) |=> s2_valid_reg)
        else $error("request lost at product stage");

endmodule

FILE: src/image_signature_validator.sv
// top level of the streaming jpeg/png signature and completeness check
// One byte of the file is taken each clock cycle on the s_ side, s_tlast marking the file's
// last byte, and files may follow one another with no gap. The first 24 bytes fill a chain of
// head cells and the last four bytes sit in a shift window; on the last byte the file is
// summarized and goes down a three-stage verdict pipeline (capture, 32x32 pixel product,
// limit compare into the output register), and m_tvalid rises once the output register is
// loaded; a stalled output holds it back. Throughput stays one byte per cycle while s_tready
// is high. While m_tready is low the pipeline holds up to three verdicts, after which
// s_tready drops until a verdict leaves. The user must write max_pixels on the cfg_ channel
// only while no file is in flight; the block does not enforce this.
module image_signature_validator
    import isv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // byte_value
    input  logic             s_tlast,   // last_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // image_valid, jpeg_path, zero fill
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data   // max_pixels
);

    logic             accept;
    logic             push;
    logic [CFG_W-1:0] max_pixels_reg;
    logic             filled [HEAD_DEPTH];
    isv_cell_view_t   view   [HEAD_DEPTH];
    byte_t            tail_reg [TAIL_DEPTH];
    isv_snap_t        snap;
    logic             png_head_ok;
    logic [1:0]       verdict;

    assign accept    = s_tvalid & s_tready;
    assign push      = accept & s_tlast;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pixels_reg <= MAX_PIXELS_RESET;
        end
        else if (cfg_valid)
        begin
            max_pixels_reg <= cfg_data;
        end
    end

    for (genvar k = 0; k < HEAD_DEPTH; k++)
    begin : g_head
        isv_head_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .clr     (s_tlast),
            .tok_in  ((k == 0) ? 1'b1 : filled[(k == 0) ? 0 : k - 1]),
            .byte_in (s_tdata),
            .filled  (filled[k]),
            .view    (view[k])
        );
    end

    // window of the most recent bytes, oldest first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < TAIL_DEPTH - 1; i++)
            begin
                tail_reg[i] <= tail_reg[i + 1];
            end
            tail_reg[TAIL_DEPTH - 1] <= s_tdata;
        end
    end

    always_comb
    begin
        png_head_ok = 1'b1;
        for (int i = 0; i < PNG_HEAD_LEN; i++)
        begin
            png_head_ok = png_head_ok & (view[i].val == PNG_HEAD[i]);
        end
    end

    // the file length gates every check, so stale entries never count
    always_comb
    begin
        snap.jpeg    = view[2].have && (view[0].val == JPEG_SOI[0])
                       && (view[1].val == JPEG_SOI[1]) && (view[2].val == JPEG_SOI[2]);
        snap.jpeg_ok = (tail_reg[TAIL_DEPTH - 1] == JPEG_EOI[0]) && (s_tdata == JPEG_EOI[1]);
        snap.png_ok  = view[HEAD_DEPTH - 1].have && png_head_ok
                       && (tail_reg[1] == PNG_IEND[0]) && (tail_reg[2] == PNG_IEND[1])
                       && (tail_reg[3] == PNG_IEND[2]) && (s_tdata == PNG_IEND[3]);
        snap.width   = {view[WIDTH_POS].val, view[WIDTH_POS + 1].val,
                        view[WIDTH_POS + 2].val, view[WIDTH_POS + 3].val};
        snap.height  = {view[HEIGHT_POS].val, view[HEIGHT_POS + 1].val,
                        view[HEIGHT_POS + 2].val, view[HEIGHT_POS + 3].val};
    end

    isv_verdict u_verdict (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (push),
        .in_ready   (s_tready),
        .in_snap    (snap),
        .max_pixels (max_pixels_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (verdict)
    );

    assign m_tdata = {6'd0, verdict};

endmodule
